// ----- sv/accumulator_cpu_core_unit_assert.svh -----
// assertion macros for the accumulator core
// used by the controller and the top level
`ifndef ACCUMULATOR_CPU_CORE_UNIT_ASSERT_SVH
`define ACCUMULATOR_CPU_CORE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define ACC_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("%m failed");
`define ACC_ASSERT_NXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("%m failed");
`else
`define ACC_ASSERT_IMP(label, clk, rst, a, b)
`define ACC_ASSERT_NXT(label, clk, rst, a, b)
`endif
`endif

// ----- sv/acc_cpu_pkg.sv -----
// shared types, constants and codes of the accumulator core
// no dependencies
package acc_cpu_pkg;
  localparam int MEM_WORDS = 1024;
  localparam int AW = $clog2(MEM_WORDS);

  localparam logic [2:0] ST_LOADED = 3'd0;
  localparam logic [2:0] ST_EXEC   = 3'd1;
  localparam logic [2:0] ST_HALT   = 3'd2;
  localparam logic [2:0] ST_DIVZ   = 3'd3;
  localparam logic [2:0] ST_BADOP  = 3'd4;

  localparam logic [31:0] OP_ADD = 32'd1;
  localparam logic [31:0] OP_SUB = 32'd2;
  localparam logic [31:0] OP_MUL = 32'd3;
  localparam logic [31:0] OP_DIV = 32'd4;
  localparam logic [31:0] OP_JMP = 32'd5;
  localparam logic [31:0] OP_JMPN = 32'd6;
  localparam logic [31:0] OP_JMPP = 32'd7;
  localparam logic [31:0] OP_JMPZ = 32'd8;
  localparam logic [31:0] OP_COPY = 32'd9;
  localparam logic [31:0] OP_LOAD = 32'd10;
  localparam logic [31:0] OP_STORE = 32'd11;
  localparam logic [31:0] OP_INPUT = 32'd12;
  localparam logic [31:0] OP_OUTPUT = 32'd13;
  localparam logic [31:0] OP_STOP = 32'd14;

  // memory address source
  localparam logic [2:0] MA_LOAD = 3'd0;
  localparam logic [2:0] MA_PC   = 3'd1;
  localparam logic [2:0] MA_PC1  = 3'd2;
  localparam logic [2:0] MA_PC2  = 3'd3;
  localparam logic [2:0] MA_A1   = 3'd4;
  localparam logic [2:0] MA_A2   = 3'd5;

  // memory word register to capture
  localparam logic [2:0] CAP_NONE = 3'd0;
  localparam logic [2:0] CAP_OP   = 3'd1;
  localparam logic [2:0] CAP_A1   = 3'd2;
  localparam logic [2:0] CAP_A2   = 3'd3;
  localparam logic [2:0] CAP_OPND = 3'd4;

  // memory write data source
  localparam logic [1:0] WD_LOAD  = 2'd0;
  localparam logic [1:0] WD_OPND  = 2'd1;
  localparam logic [1:0] WD_ACC   = 2'd2;
  localparam logic [1:0] WD_INPUT = 2'd3;

  typedef struct packed {
    logic        in_load;
    logic [2:0]  mem_addr_sel;
    logic        mem_we;
    logic [1:0]  wdata_sel;
    logic [2:0]  capture;
    logic        exec;        // apply the instruction
    logic        div_start;
    logic        result_load;
    logic [2:0]  result_status;
  } acc_cmd_t;

  typedef struct packed {
    logic [31:0] opcode;
    logic        op_divz;
    logic        div_done;
    logic        req_type;
  } acc_stat_t;
endpackage

// ----- sv/acc_cpu_if.sv -----
// valid/ready channel interfaces of the accumulator core
// depends on nothing
interface acc_cpu_req_if (input logic clk);
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [9:0]  load_address;
  logic signed [31:0] load_value;
  logic signed [31:0] input_value;
  modport source (output valid, req_type, load_address, load_value, input_value, input ready);
  modport sink (input valid, req_type, load_address, load_value, input_value, output ready);
endinterface

interface acc_cpu_rsp_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic signed [31:0] accumulator;
  logic [9:0]  next_pc;
  logic        wrote_memory;
  logic [9:0]  written_address;
  logic signed [31:0] written_value;
  logic        output_valid;
  logic signed [31:0] output_value;
  logic        input_taken;
  modport source (output valid, status, accumulator, next_pc, wrote_memory,
    written_address, written_value, output_valid, output_value, input_taken, input ready);
  modport sink (input valid, status, accumulator, next_pc, wrote_memory,
    written_address, written_value, output_valid, output_value, input_taken, output ready);
endinterface

// ----- sv/acc_cpu_div.sv -----
// iterative signed divider, one quotient bit a cycle, truncating toward zero
// depends on nothing
module acc_cpu_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [31:0] quot
);
  logic [31:0] rem, q, dm;
  logic [5:0]  cnt;
  logic        busy, neg;
  logic [32:0] trial;

  assign trial = {rem[31:0], q[31]} - {1'b0, dm};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
        rem  <= 32'd0;
        q    <= num[31] ? (32'd0 - num) : num;
        dm   <= den[31] ? (32'd0 - den) : den;
        neg  <= num[31] ^ den[31];
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial[31:0];
          q   <= {q[30:0], 1'b1};
        end else begin
          rem <= {rem[30:0], q[31]};
          q   <= {q[30:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = neg ? (32'd0 - q) : q;
endmodule

// ----- sv/acc_cpu_dp.sv -----
// datapath: word memory, pc, acc, operand registers, divider, result register
// depends on acc_cpu_pkg and acc_cpu_div
module acc_cpu_dp (
  input  logic                clk,
  input  logic                rst,
  input  acc_cpu_pkg::acc_cmd_t cmd,
  output acc_cpu_pkg::acc_stat_t stat,
  input  logic                in_req_type,
  input  logic [9:0]          in_load_address,
  input  logic [31:0]         in_load_value,
  input  logic [31:0]         in_input_value,
  output logic [2:0]          r_status,
  output logic [31:0]         r_acc,
  output logic [9:0]          r_pc,
  output logic                r_wrote,
  output logic [9:0]          r_waddr,
  output logic [31:0]         r_wval,
  output logic                r_ovalid,
  output logic [31:0]         r_oval,
  output logic                r_taken
);
  logic [31:0] mem [acc_cpu_pkg::MEM_WORDS];
  logic [31:0] rdata;
  logic [acc_cpu_pkg::AW-1:0] pc, a1, a2, maddr;
  logic [31:0] acc, acc_next, opcode, opnd, ival, wdata, mulr;
  logic        rtype;
  logic [acc_cpu_pkg::AW-1:0] pc_next;
  logic        wrote_next, ovalid_next, taken_next;
  logic [acc_cpu_pkg::AW-1:0] seq2, seq3;
  logic        div_done;
  logic [31:0] quot;

  acc_cpu_div u_div (.clk(clk), .rst(rst), .start(cmd.div_start), .num(acc),
    .den(opnd), .done(div_done), .quot(quot));

  assign seq2 = pc + acc_cpu_pkg::AW'(2);
  assign seq3 = pc + acc_cpu_pkg::AW'(3);

  always_comb begin
    case (cmd.mem_addr_sel)
      acc_cpu_pkg::MA_LOAD: maddr = acc_cpu_pkg::AW'(in_load_address);
      acc_cpu_pkg::MA_PC:   maddr = pc;
      acc_cpu_pkg::MA_PC1:  maddr = pc + acc_cpu_pkg::AW'(1);
      acc_cpu_pkg::MA_PC2:  maddr = seq2;
      acc_cpu_pkg::MA_A1:   maddr = a1;
      acc_cpu_pkg::MA_A2:   maddr = a2;
      default:              maddr = pc;
    endcase
    case (cmd.wdata_sel)
      acc_cpu_pkg::WD_LOAD: wdata = in_load_value;
      acc_cpu_pkg::WD_OPND: wdata = opnd;
      acc_cpu_pkg::WD_ACC:  wdata = acc;
      default:              wdata = ival;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_we) mem[maddr] <= wdata;
    rdata <= mem[maddr];
  end

  // capture is issued the cycle after the read address
  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      rtype <= in_req_type;
      ival  <= in_input_value;
    end
    case (cmd.capture)
      acc_cpu_pkg::CAP_OP:   opcode <= rdata;
      acc_cpu_pkg::CAP_A1:   a1 <= rdata[acc_cpu_pkg::AW-1:0];
      acc_cpu_pkg::CAP_A2:   a2 <= rdata[acc_cpu_pkg::AW-1:0];
      acc_cpu_pkg::CAP_OPND: opnd <= rdata;
      default: ;
    endcase
    mulr <= acc * opnd;
  end

  always_comb begin
    acc_next = acc;
    pc_next = seq2;
    wrote_next = 1'b0;
    ovalid_next = 1'b0;
    taken_next = 1'b0;
    case (opcode)
      acc_cpu_pkg::OP_ADD:  acc_next = acc + opnd;
      acc_cpu_pkg::OP_SUB:  acc_next = acc - opnd;
      acc_cpu_pkg::OP_MUL:  acc_next = mulr;
      acc_cpu_pkg::OP_DIV:  if (opnd != 32'd0) acc_next = quot;
      acc_cpu_pkg::OP_JMP:  pc_next = a1;
      acc_cpu_pkg::OP_JMPN: if (acc[31]) pc_next = a1;
      acc_cpu_pkg::OP_JMPP: if (!acc[31] && acc != 32'd0) pc_next = a1;
      acc_cpu_pkg::OP_JMPZ: if (acc == 32'd0) pc_next = a1;
      acc_cpu_pkg::OP_COPY: begin
        pc_next = seq3;
        wrote_next = 1'b1;
      end
      acc_cpu_pkg::OP_LOAD: acc_next = opnd;
      acc_cpu_pkg::OP_STORE: wrote_next = 1'b1;
      acc_cpu_pkg::OP_INPUT: begin
        wrote_next = 1'b1;
        taken_next = 1'b1;
      end
      acc_cpu_pkg::OP_OUTPUT: ovalid_next = 1'b1;
      default: pc_next = pc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc  <= '0;
      acc <= '0;
    end else if (cmd.exec) begin
      pc  <= pc_next;
      acc <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      r_status <= cmd.result_status;
      r_acc    <= cmd.exec ? acc_next : acc;
      r_pc     <= 10'(cmd.exec ? pc_next : pc);
      r_wrote  <= cmd.exec & wrote_next;
      r_waddr  <= (cmd.exec & wrote_next) ?
                  10'((opcode == acc_cpu_pkg::OP_COPY) ? a2 : a1) : 10'd0;
      r_wval   <= !(cmd.exec & wrote_next) ? 32'd0 :
                  (opcode == acc_cpu_pkg::OP_COPY) ? opnd :
                  (opcode == acc_cpu_pkg::OP_STORE) ? acc : ival;
      r_ovalid <= cmd.exec & ovalid_next;
      r_oval   <= (cmd.exec & ovalid_next) ? opnd : 32'd0;
      r_taken  <= cmd.exec & taken_next;
    end
  end

  assign stat.opcode   = opcode;
  assign stat.op_divz  = (opnd == 32'd0);
  assign stat.div_done = div_done;
  assign stat.req_type = rtype;
endmodule

// ----- sv/acc_cpu_ctrl.sv -----
// controller state machine sequencing memory reads, execution and result
// depends on acc_cpu_pkg and the assertion header
`include "accumulator_cpu_core_unit_assert.svh"
module acc_cpu_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  acc_cpu_pkg::acc_stat_t stat,
  output acc_cpu_pkg::acc_cmd_t  cmd
);
  localparam logic [3:0] S_IDLE = 4'd0, S_OPRD = 4'd1, S_OPCAP = 4'd2,
    S_A1CAP = 4'd3, S_A2CAP = 4'd4, S_OPNDRD = 4'd5, S_OPNDCAP = 4'd6,
    S_MUL = 4'd7, S_DIV = 4'd8, S_EXEC = 4'd9, S_WAIT = 4'd10;

  logic [3:0] state, state_next;
  logic halted, halted_next, out_valid_next;
  logic [31:0] op;

  assign op = stat.opcode;
  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);

  always_comb begin
    cmd = '0;
    state_next = state;
    halted_next = halted;
    out_valid_next = out_valid && !out_ready;
    case (state)
      S_IDLE: begin
        // a load item writes straight from the port at acceptance
        cmd.mem_addr_sel = acc_cpu_pkg::MA_LOAD;
        if (in_valid && in_ready) begin
          state_next = S_OPRD;
          cmd.in_load = 1'b1;
        end
      end
      S_OPRD: begin
        if (!stat.req_type) begin
          // load item already written, report it
          cmd.result_load = 1'b1;
          cmd.result_status = acc_cpu_pkg::ST_LOADED;
          out_valid_next = 1'b1;
          state_next = S_IDLE;
        end else if (halted) begin
          cmd.result_load = 1'b1;
          cmd.result_status = acc_cpu_pkg::ST_HALT;
          out_valid_next = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.mem_addr_sel = acc_cpu_pkg::MA_PC;
          state_next = S_OPCAP;
        end
      end
      S_OPCAP: begin
        cmd.capture = acc_cpu_pkg::CAP_OP;
        cmd.mem_addr_sel = acc_cpu_pkg::MA_PC1;
        state_next = S_A1CAP;
      end
      S_A1CAP: begin
        cmd.capture = acc_cpu_pkg::CAP_A1;
        cmd.mem_addr_sel = acc_cpu_pkg::MA_PC2;
        state_next = S_A2CAP;
      end
      S_A2CAP: begin
        cmd.capture = acc_cpu_pkg::CAP_A2;
        state_next = S_OPNDRD;
      end
      S_OPNDRD: begin
        cmd.mem_addr_sel = acc_cpu_pkg::MA_A1;
        state_next = S_OPNDCAP;
      end
      S_OPNDCAP: begin
        cmd.capture = acc_cpu_pkg::CAP_OPND;
        if (op == acc_cpu_pkg::OP_MUL) state_next = S_MUL;
        else if (op == acc_cpu_pkg::OP_DIV) state_next = S_DIV;
        else state_next = S_EXEC;
      end
      S_MUL: state_next = S_EXEC;
      S_DIV: begin
        if (stat.op_divz) state_next = S_EXEC;
        else begin
          cmd.div_start = 1'b1;
          state_next = S_WAIT;
        end
      end
      S_WAIT: if (stat.div_done) state_next = S_EXEC;
      S_EXEC: begin
        cmd.result_load = 1'b1;
        out_valid_next = 1'b1;
        state_next = S_IDLE;
        if (op == acc_cpu_pkg::OP_STOP) begin
          halted_next = 1'b1;
          cmd.result_status = acc_cpu_pkg::ST_HALT;
        end else if (op < acc_cpu_pkg::OP_ADD || op > acc_cpu_pkg::OP_STOP) begin
          cmd.result_status = acc_cpu_pkg::ST_BADOP;
        end else begin
          cmd.exec = 1'b1;
          cmd.result_status = (op == acc_cpu_pkg::OP_DIV && stat.op_divz) ?
            acc_cpu_pkg::ST_DIVZ : acc_cpu_pkg::ST_EXEC;
          if (op == acc_cpu_pkg::OP_COPY) begin
            cmd.mem_we = 1'b1;
            cmd.mem_addr_sel = acc_cpu_pkg::MA_A2;
            cmd.wdata_sel = acc_cpu_pkg::WD_OPND;
          end else if (op == acc_cpu_pkg::OP_STORE) begin
            cmd.mem_we = 1'b1;
            cmd.mem_addr_sel = acc_cpu_pkg::MA_A1;
            cmd.wdata_sel = acc_cpu_pkg::WD_ACC;
          end else if (op == acc_cpu_pkg::OP_INPUT) begin
            cmd.mem_we = 1'b1;
            cmd.mem_addr_sel = acc_cpu_pkg::MA_A1;
            cmd.wdata_sel = acc_cpu_pkg::WD_INPUT;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      halted <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      halted <= halted_next;
      out_valid <= out_valid_next;
    end
  end

  `ACC_ASSERT_IMP(a_ready_idle, clk, rst, in_ready, state == S_IDLE)
  `ACC_ASSERT_NXT(a_halt_sticks, clk, rst, halted, halted)
  `ACC_ASSERT_IMP(a_we_exec, clk, rst, cmd.mem_we && state != S_IDLE, cmd.exec)
endmodule

// ----- sv/accumulator_cpu_core_unit.sv -----
// top level of the accumulator core: joins controller and datapath
// depends on acc_cpu_pkg, acc_cpu_if, acc_cpu_ctrl, acc_cpu_dp and the assertion header
//
// req channel: one item per request; req_type 0 writes load_value to memory
// at load_address, req_type 1 runs one instruction at the program counter.
// rsp channel: one item for every request item; a load item writes memory at
// acceptance and its status-0 item is registered from the S_OPRD state,
// as is the item of a step made while halted.
// an instruction steps through opcode, operand-address and operand read
// and capture states before it executes, a divide by nonzero also waiting
// on the one-bit-a-cycle divider; one memory port serialises those reads.
// one item is in flight at a time; the next is accepted once the block is
// back at idle and the result register is free or being taken.
// reset clears pc, acc, the halt flag and the controller; memory is not
// cleared and must be loaded before it is read.
// a stalled receiver holds the result; no further item is taken meanwhile.
`include "accumulator_cpu_core_unit_assert.svh"
module accumulator_cpu_core_unit (
  input logic clk,
  input logic rst,
  acc_cpu_req_if.sink req,
  acc_cpu_rsp_if.source rsp
);
  acc_cpu_pkg::acc_cmd_t  cmd;
  acc_cpu_pkg::acc_stat_t stat;
  logic [2:0]  r_status;
  logic [31:0] r_acc, r_wval, r_oval;
  logic [9:0]  r_pc, r_waddr;
  logic        r_wrote, r_ovalid, r_taken;
  acc_cpu_pkg::acc_cmd_t cmd_dp;
  logic        rsp_valid_c;
  logic        acc_in;

  assign acc_in = req.valid && req.ready;

  acc_cpu_ctrl u_ctrl (.clk(clk), .rst(rst), .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(rsp_valid_c), .out_ready(rsp.ready), .stat(stat), .cmd(cmd));

  // load item: write memory in the accept cycle, the controller reports it
  always_comb begin
    cmd_dp = cmd;
    if (acc_in && !req.req_type) begin
      cmd_dp.mem_we = 1'b1;
      cmd_dp.wdata_sel = acc_cpu_pkg::WD_LOAD;
    end
  end

  acc_cpu_dp u_dp (.clk(clk), .rst(rst), .cmd(cmd_dp), .stat(stat),
    .in_req_type(req.req_type), .in_load_address(req.load_address),
    .in_load_value(req.load_value), .in_input_value(req.input_value),
    .r_status(r_status), .r_acc(r_acc), .r_pc(r_pc), .r_wrote(r_wrote),
    .r_waddr(r_waddr), .r_wval(r_wval), .r_ovalid(r_ovalid), .r_oval(r_oval),
    .r_taken(r_taken));

  assign rsp.valid = rsp_valid_c;
  assign rsp.status = r_status;
  assign rsp.accumulator = r_acc;
  assign rsp.next_pc = r_pc;
  assign rsp.wrote_memory = r_wrote;
  assign rsp.written_address = r_waddr;
  assign rsp.written_value = r_wval;
  assign rsp.output_valid = r_ovalid;
  assign rsp.output_value = r_oval;
  assign rsp.input_taken = r_taken;

  `ACC_ASSERT_IMP(a_no_accept_busy, clk, rst, rsp.valid && !rsp.ready, !req.ready)
  `ACC_ASSERT_NXT(a_rsp_held, clk, rst, rsp.valid && !rsp.ready, rsp.valid)
  `ACC_ASSERT_NXT(a_one_in_flight, clk, rst, acc_in, !req.ready)
endmodule

// ----- tb/sv/accumulator_cpu_core_unit_tb.sv -----
`timescale 1ns / 1ps
// testbench for the accumulator core: a program generator with its own machine model,
// a driver and a monitor on the valid/ready channels
// depends on acc_cpu_pkg, acc_cpu_if and the accumulator_cpu_core_unit rtl
module accumulator_cpu_core_unit_tb;
  localparam int LIMIT_CYCLES = 2000000;
  localparam int RANDOM_ITEMS = 1950;
  localparam int QUIET_TAIL = 150;

  typedef struct {
    logic        req_type;
    logic [9:0]  load_address;
    logic [31:0] load_value;
    logic [31:0] input_value;
  } cpu_req_t;

  typedef struct {
    logic [2:0]  status;
    logic [31:0] accumulator;
    logic [9:0]  next_pc;
    logic        wrote_memory;
    logic [9:0]  written_address;
    logic [31:0] written_value;
    logic        output_valid;
    logic [31:0] output_value;
    logic        input_taken;
  } cpu_rsp_t;

  typedef struct {
    cpu_req_t req;
    cpu_rsp_t rsp;
  } cpu_item_t;

  logic clk;
  logic rst;

  acc_cpu_req_if req (clk);
  acc_cpu_rsp_if rsp (clk);

  accumulator_cpu_core_unit u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // machine state as the generator sees it, updated as each item is queued
  logic [31:0] model_mem [acc_cpu_pkg::MEM_WORDS];
  bit          model_known [acc_cpu_pkg::MEM_WORDS];
  logic [9:0]  model_pc;
  logic [31:0] model_acc;
  bit          model_halted;

  cpu_item_t pending_items[$];
  cpu_rsp_t  expected_results[$];
  cpu_item_t cur_item;
  bit        gen_done;
  int        errors;
  int        req_gap;
  int        rsp_gap;
  int        cycles;
  bit        quiet;

  initial begin
    clk = 1'b0;
    forever begin
      #5 clk = 1'b1;
      #5 clk = 1'b0;
    end
  end

  // runs one item through the model and returns the result it should produce
  function automatic cpu_rsp_t run_machine(cpu_req_t r);
    cpu_rsp_t    o;
    logic [31:0] op;
    logic [31:0] opnd;
    logic [9:0]  a1;
    logic [9:0]  a2;
    logic [9:0]  seq;
    o = '{default: '0};
    o.status = acc_cpu_pkg::ST_EXEC;
    if (!r.req_type) begin
      model_mem[r.load_address] = r.load_value;
      model_known[r.load_address] = 1'b1;
      o.status = acc_cpu_pkg::ST_LOADED;
    end else if (model_halted) begin
      o.status = acc_cpu_pkg::ST_HALT;
    end else begin
      op = model_mem[model_pc];
      a1 = model_mem[10'(model_pc + 10'd1)][9:0];
      a2 = model_mem[10'(model_pc + 10'd2)][9:0];
      seq = model_pc + 10'd2;
      opnd = model_mem[a1];
      case (op)
        acc_cpu_pkg::OP_ADD: begin model_acc = model_acc + opnd; model_pc = seq; end
        acc_cpu_pkg::OP_SUB: begin model_acc = model_acc - opnd; model_pc = seq; end
        acc_cpu_pkg::OP_MUL: begin model_acc = model_acc * opnd; model_pc = seq; end
        acc_cpu_pkg::OP_DIV: begin
          if (opnd == 32'd0) o.status = acc_cpu_pkg::ST_DIVZ;
          else if (!(model_acc == 32'h8000_0000 && opnd == 32'hffff_ffff))
            model_acc = $signed(model_acc) / $signed(opnd);
          model_pc = seq;
        end
        acc_cpu_pkg::OP_JMP: model_pc = a1;
        acc_cpu_pkg::OP_JMPN: model_pc = model_acc[31] ? a1 : seq;
        acc_cpu_pkg::OP_JMPP: model_pc = (!model_acc[31] && model_acc != 0) ? a1 : seq;
        acc_cpu_pkg::OP_JMPZ: model_pc = (model_acc == 0) ? a1 : seq;
        acc_cpu_pkg::OP_COPY: begin
          model_mem[a2] = opnd;
          model_known[a2] = 1'b1;
          o.wrote_memory = 1'b1;
          o.written_address = a2;
          o.written_value = opnd;
          model_pc = model_pc + 10'd3;
        end
        acc_cpu_pkg::OP_LOAD: begin model_acc = opnd; model_pc = seq; end
        acc_cpu_pkg::OP_STORE: begin
          model_mem[a1] = model_acc;
          model_known[a1] = 1'b1;
          o.wrote_memory = 1'b1;
          o.written_address = a1;
          o.written_value = model_acc;
          model_pc = seq;
        end
        acc_cpu_pkg::OP_INPUT: begin
          model_mem[a1] = r.input_value;
          model_known[a1] = 1'b1;
          o.wrote_memory = 1'b1;
          o.written_address = a1;
          o.written_value = r.input_value;
          o.input_taken = 1'b1;
          model_pc = seq;
        end
        acc_cpu_pkg::OP_OUTPUT: begin
          o.output_valid = 1'b1;
          o.output_value = opnd;
          model_pc = seq;
        end
        acc_cpu_pkg::OP_STOP: begin
          model_halted = 1'b1;
          o.status = acc_cpu_pkg::ST_HALT;
        end
        default: o.status = acc_cpu_pkg::ST_BADOP;
      endcase
    end
    o.accumulator = model_acc;
    o.next_pc = model_pc;
    return o;
  endfunction

  function automatic void queue_item(logic rt, logic [9:0] addr, logic [31:0] value,
                                     logic [31:0] in_value);
    cpu_item_t it;
    it.req = '{rt, addr, value, in_value};
    it.rsp = run_machine(it.req);
    pending_items.push_back(it);
  endfunction

  function automatic logic [31:0] pick_data();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      3: return 32'hffff_ffff;
      4: return 32'($urandom_range(0, 40)) - 32'd20;
      default: return $urandom;
    endcase
  endfunction

  // mostly a small data region, sometimes a full 32-bit word that wraps
  function automatic logic [31:0] pick_addr();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'd1023;
      default: return 32'($urandom_range(0, 63));
    endcase
  endfunction

  function automatic void put_word(logic [9:0] addr, logic [31:0] value);
    queue_item(1'b0, addr, value, $urandom);
  endfunction

  function automatic void step_machine(logic [31:0] in_value);
    queue_item(1'b1, 10'($urandom), $urandom, in_value);
  endfunction

  function automatic bit reads_operand(logic [31:0] op);
    return op inside {acc_cpu_pkg::OP_ADD, acc_cpu_pkg::OP_SUB, acc_cpu_pkg::OP_MUL,
                      acc_cpu_pkg::OP_DIV, acc_cpu_pkg::OP_COPY, acc_cpu_pkg::OP_LOAD,
                      acc_cpu_pkg::OP_OUTPUT};
  endfunction

  // back the instruction at pc with written words, at times with a bad opcode, then step it
  function automatic void random_step();
    logic [9:0]  pc;
    logic [9:0]  p1;
    logic [9:0]  p2;
    logic [9:0]  a1;
    logic [31:0] op;
    int          r;
    if ($urandom_range(0, 7) == 0) put_word(10'($urandom), $urandom);
    pc = model_pc;
    p1 = pc + 10'd1;
    p2 = pc + 10'd2;
    if (!model_known[pc] || model_mem[pc] == acc_cpu_pkg::OP_STOP
        || $urandom_range(0, 2) == 0) begin
      r = $urandom_range(0, 29);
      if (r < 26) op = 32'(r % 13 + 1);
      else begin
        case (r)
          26: op = 32'd0;
          27: op = 32'd15;
          28: op = 32'hffff_ffff;
          default: op = $urandom | 32'h0001_0000;
        endcase
      end
      put_word(pc, op);
    end
    if (!model_known[p1] || $urandom_range(0, 3) == 0) put_word(p1, pick_addr());
    op = model_mem[pc];
    if (op == acc_cpu_pkg::OP_COPY && (!model_known[p2] || $urandom_range(0, 1) == 0))
      put_word(p2, pick_addr());
    a1 = model_mem[p1][9:0];
    if (reads_operand(op) && !model_known[a1]) put_word(a1, pick_data());
    if (op == acc_cpu_pkg::OP_DIV && a1 != pc && a1 != p1 && $urandom_range(0, 3) == 0)
      put_word(a1, $urandom_range(0, 1) ? 32'd0 : 32'hffff_ffff);
    step_machine(pick_data());
  endfunction

  initial begin
    logic [31:0] prog [];
    for (int i = 0; i < acc_cpu_pkg::MEM_WORDS; i++) begin
      model_mem[i] = '0;
      model_known[i] = 1'b0;
    end
    model_pc = '0;
    model_acc = '0;
    model_halted = 1'b0;
    gen_done = 1'b0;

    // extreme operands, then a short program through divide overflow, divide by zero, add,
    // multiply, a store to an address that wraps, input, output, copy and sub
    put_word(10'd100, 32'h8000_0000);
    put_word(10'd101, 32'hffff_ffff);
    put_word(10'd102, 32'd0);
    put_word(10'd103, 32'h7fff_ffff);
    prog = '{acc_cpu_pkg::OP_LOAD, 100, acc_cpu_pkg::OP_DIV, 101,
             acc_cpu_pkg::OP_DIV, 102, acc_cpu_pkg::OP_ADD, 103,
             acc_cpu_pkg::OP_MUL, 101, acc_cpu_pkg::OP_STORE, 1124,
             acc_cpu_pkg::OP_INPUT, 1023, acc_cpu_pkg::OP_OUTPUT, 1023,
             acc_cpu_pkg::OP_COPY, 103, 101, acc_cpu_pkg::OP_SUB, 103};
    foreach (prog[i]) put_word(10'(i), prog[i]);
    for (int i = 0; i < 10; i++) step_machine(i == 6 ? 32'h8000_0000 : 32'h7fff_ffff);

    while (pending_items.size() < RANDOM_ITEMS) random_step();

    // halt, a step while halted, a load while halted, another step
    put_word(model_pc, acc_cpu_pkg::OP_STOP);
    if (!model_known[10'(model_pc + 10'd1)]) put_word(model_pc + 10'd1, 32'd0);
    step_machine($urandom);
    step_machine($urandom);
    put_word(10'($urandom), $urandom);
    step_machine($urandom);
    gen_done = 1'b1;
  end

  always @(posedge clk) begin
    quiet <= gen_done && pending_items.size() < QUIET_TAIL;
  end

  initial begin
    rst = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  // driver: an item is held until taken; gaps only fall between items
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      req.req_type <= 1'b0;
      req.load_address <= '0;
      req.load_value <= '0;
      req.input_value <= '0;
    end else begin
      if (req.valid && req.ready) expected_results.push_back(cur_item.rsp);
      if (req.valid && !req.ready) begin
      end else if (req_gap > 0) begin
        req_gap--;
        req.valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        req_gap = $urandom_range(1, 18) - 1;
        req.valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        cur_item = pending_items.pop_front();
        req.valid <= 1'b1;
        req.req_type <= cur_item.req.req_type;
        req.load_address <= cur_item.req.load_address;
        req.load_value <= cur_item.req.load_value;
        req.input_value <= cur_item.req.input_value;
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (rsp_gap > 0) begin
      rsp_gap--;
      rsp.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      rsp_gap = $urandom_range(1, 18) - 1;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $error("%s: expected %h, got %h", name, exp_v, act_v);
    end
  endfunction

  // monitor
  always @(posedge clk) begin
    cpu_rsp_t e;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_results.size() == 0) begin
        errors++;
        $error("result item with nothing expected");
      end else begin
        e = expected_results.pop_front();
        check_field("status", 32'(e.status), 32'(rsp.status));
        check_field("accumulator", e.accumulator, rsp.accumulator);
        check_field("next_pc", 32'(e.next_pc), 32'(rsp.next_pc));
        check_field("wrote_memory", 32'(e.wrote_memory), 32'(rsp.wrote_memory));
        check_field("written_address", 32'(e.written_address), 32'(rsp.written_address));
        check_field("written_value", e.written_value, rsp.written_value);
        check_field("output_valid", 32'(e.output_valid), 32'(rsp.output_valid));
        check_field("output_value", e.output_value, rsp.output_value);
        check_field("input_taken", 32'(e.input_taken), 32'(rsp.input_taken));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("** accumulator_cpu_core_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    @(negedge rst);
    while (!gen_done || pending_items.size() != 0 || req.valid
           || expected_results.size() != 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("** accumulator_cpu_core_unit: PASSED **");
    end else begin
      $display("** accumulator_cpu_core_unit: FAILED **");
    end
    $finish;
  end
endmodule

// ----- accumulator_cpu_core_unit.f -----
+incdir+sv
sv/acc_cpu_pkg.sv
sv/acc_cpu_if.sv
sv/acc_cpu_div.sv
sv/acc_cpu_dp.sv
sv/acc_cpu_ctrl.sv
sv/accumulator_cpu_core_unit.sv
tb/sv/accumulator_cpu_core_unit_tb.sv
